[rtl/core/nrr_pkg.sv]
// ----------------------------------------------------------------------------
// nrr_pkg: shared types and constants of the nearest resize normalizer
// Holds the configuration register indexes, fixed field widths and the
// record that travels from the scan stage to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package nrr_pkg;

  // Configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAM_W     = 3'd0,
    CFG_CAM_H     = 3'd1,
    CFG_OUT_W     = 3'd2,
    CFG_OUT_H     = 3'd3,
    CFG_NORM_MODE = 3'd4
  } cfg_idx_e;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] CAM_W_RST = 11'd320;
  localparam logic [CFG_W-1:0] CAM_H_RST = 11'd240;
  localparam logic [CFG_W-1:0] OUT_W_RST = 11'd96;
  localparam logic [CFG_W-1:0] OUT_H_RST = 11'd96;

  // Field widths
  localparam int PIX_W       = 16;
  localparam int NORM_W      = 16;
  localparam int COORD_W     = 10;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 72;

  // One picked pixel with its target coordinates
  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } item_t;

endpackage

`default_nettype wire

[rtl/core/nrr_scan.sv]
// ----------------------------------------------------------------------------
// nrr_scan: source/target counters and nearest-neighbor pick
// Walks the camera raster, decides which source pixels are kept and
// registers each kept pixel with its target coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module nrr_scan import nrr_pkg::*; #(
  parameter int  MAX_DIM = 1024,
  localparam int DIM_W   = $clog2(MAX_DIM + 1)
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire [DIM_W-1:0]  cw_i,
  input  wire [DIM_W-1:0]  ch_i,
  input  wire [DIM_W-1:0]  ow_i,
  input  wire [DIM_W-1:0]  oh_i,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wire [PIX_W-1:0]  in_pixel_i,
  input  wire              in_frame_start_i,
  output logic             item_valid_o,
  output item_t            item_o,
  input  wire              item_ready_i
);

  localparam int XW = DIM_W + 1;

  // The pick position is tracked as a distance: dist counts down by the
  // latched step for every source position passed, and the current position
  // is the pick when dist is below the step. This equals the exact
  // quotient/remainder walk without any divider. Once a pick has been
  // skipped, the distance is frozen until the counters are cleared.
  logic [DIM_W-1:0] src_col_q, src_col_d, src_row_q, src_row_d;
  logic [DIM_W-1:0] tgt_col_q, tgt_col_d, tgt_row_q, tgt_row_d;
  logic [XW-1:0]    col_dist_q, col_dist_d, row_dist_q, row_dist_d;
  logic [DIM_W-1:0] col_step_q, col_step_d, row_step_q, row_step_d;
  logic             col_passed_q, col_passed_d, row_passed_q, row_passed_d;
  logic             item_valid_q, item_valid_d;
  item_t            item_q;

  logic [DIM_W-1:0] src_col_e, src_row_e, tgt_col_e, tgt_row_e;
  logic [XW-1:0]    col_dist_e, row_dist_e;
  logic [DIM_W-1:0] col_step_e, row_step_e;
  logic             col_passed_e, row_passed_e;
  logic             accept, col_at, row_at, pick, end_row, end_frame;
  item_t            item_d;

  assign in_ready_o = !item_valid_q || item_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Frame start clears everything before the pixel is looked at.
  always_comb begin
    if (in_frame_start_i) begin
      src_col_e    = '0;
      src_row_e    = '0;
      tgt_col_e    = '0;
      tgt_row_e    = '0;
      col_dist_e   = '0;
      row_dist_e   = '0;
      col_step_e   = DIM_W'(1);
      row_step_e   = DIM_W'(1);
      col_passed_e = 1'b0;
      row_passed_e = 1'b0;
    end else begin
      src_col_e    = src_col_q;
      src_row_e    = src_row_q;
      tgt_col_e    = tgt_col_q;
      tgt_row_e    = tgt_row_q;
      col_dist_e   = col_dist_q;
      row_dist_e   = row_dist_q;
      col_step_e   = col_step_q;
      row_step_e   = row_step_q;
      col_passed_e = col_passed_q;
      row_passed_e = row_passed_q;
    end
  end

  assign row_at    = !row_passed_e && (row_dist_e < {1'b0, row_step_e});
  assign col_at    = !col_passed_e && (col_dist_e < {1'b0, col_step_e});
  assign pick      = row_at && col_at && (tgt_row_e < oh_i) && (tgt_col_e < ow_i);
  assign end_row   = ({1'b0, src_col_e} + XW'(1)) >= {1'b0, cw_i};
  assign end_frame = ({1'b0, src_row_e} + XW'(1)) >= {1'b0, ch_i};

  always_comb begin
    src_col_d    = src_col_q;
    src_row_d    = src_row_q;
    tgt_col_d    = tgt_col_q;
    tgt_row_d    = tgt_row_q;
    col_dist_d   = col_dist_q;
    row_dist_d   = row_dist_q;
    col_step_d   = col_step_q;
    row_step_d   = row_step_q;
    col_passed_d = col_passed_q;
    row_passed_d = row_passed_q;
    if (accept) begin
      src_row_d    = src_row_e;
      tgt_row_d    = tgt_row_e;
      row_dist_d   = row_dist_e;
      row_step_d   = row_step_e;
      row_passed_d = row_passed_e;
      if (end_row) begin
        src_col_d    = '0;
        tgt_col_d    = '0;
        col_dist_d   = '0;
        col_step_d   = DIM_W'(1);
        col_passed_d = 1'b0;
        if (row_at && (tgt_row_e < oh_i)) begin
          tgt_row_d  = tgt_row_e + DIM_W'(1);
          row_dist_d = row_dist_e + {1'b0, ch_i} - {1'b0, oh_i};
          row_step_d = oh_i;
        end else if (row_at) begin
          row_passed_d = 1'b1;
        end else if (!row_passed_e) begin
          row_dist_d = row_dist_e - {1'b0, row_step_e};
        end
        if (end_frame) begin
          src_row_d    = '0;
          tgt_row_d    = '0;
          row_dist_d   = '0;
          row_step_d   = DIM_W'(1);
          row_passed_d = 1'b0;
        end else begin
          src_row_d = src_row_e + DIM_W'(1);
        end
      end else begin
        src_col_d    = src_col_e + DIM_W'(1);
        tgt_col_d    = tgt_col_e;
        col_dist_d   = col_dist_e;
        col_step_d   = col_step_e;
        col_passed_d = col_passed_e;
        if (pick) begin
          tgt_col_d  = tgt_col_e + DIM_W'(1);
          col_dist_d = col_dist_e + {1'b0, cw_i} - {1'b0, ow_i};
          col_step_d = ow_i;
        end else if (col_at) begin
          col_passed_d = 1'b1;
        end else if (!col_passed_e) begin
          col_dist_d = col_dist_e - {1'b0, col_step_e};
        end
      end
    end
  end

  always_comb begin
    item_d.pixel = in_pixel_i;
    item_d.col   = COORD_W'(tgt_col_e);
    item_d.row   = COORD_W'(tgt_row_e);
    item_d.last  = (tgt_col_e == ow_i - DIM_W'(1)) && (tgt_row_e == oh_i - DIM_W'(1));
    item_valid_d = item_valid_q;
    if (in_ready_o) begin
      item_valid_d = accept && pick;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q    <= '0;
      src_row_q    <= '0;
      tgt_col_q    <= '0;
      tgt_row_q    <= '0;
      col_dist_q   <= '0;
      row_dist_q   <= '0;
      col_step_q   <= DIM_W'(1);
      row_step_q   <= DIM_W'(1);
      col_passed_q <= 1'b0;
      row_passed_q <= 1'b0;
      item_valid_q <= 1'b0;
    end else begin
      src_col_q    <= src_col_d;
      src_row_q    <= src_row_d;
      tgt_col_q    <= tgt_col_d;
      tgt_row_q    <= tgt_row_d;
      col_dist_q   <= col_dist_d;
      row_dist_q   <= row_dist_d;
      col_step_q   <= col_step_d;
      row_step_q   <= row_step_d;
      col_passed_q <= col_passed_d;
      row_passed_q <= row_passed_d;
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pick) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;

`ifndef NO_ASSERTIONS
  a_step_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_step_q != '0) && (row_step_q != '0))
    else $error("pick step register holds zero");

  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_dist_q <= XW'(2 * MAX_DIM - 2)) && (row_dist_q <= XW'(2 * MAX_DIM - 2)))
    else $error("pick distance out of range");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_frame_start_i |=>
      (src_row_q <= DIM_W'(1)) && (tgt_row_q <= DIM_W'(1)) && (tgt_col_q <= DIM_W'(1)))
    else $error("counters not cleared by frame start");

  a_pick_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && pick |=> item_valid_q)
    else $error("picked pixel was not registered");
`endif

endmodule

`default_nettype wire

[rtl/core/nrr_out.sv]
// ----------------------------------------------------------------------------
// nrr_out: channel expansion, Q2.14 normalization and result register
// Widens RGB565 to 8-bit channels and scales them to 0..1 or -1..1.
// ----------------------------------------------------------------------------
`default_nettype none

module nrr_out import nrr_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                norm_mode_i,
  input  wire                item_valid_i,
  input  item_t              item_i,
  output logic               item_ready_o,
  output logic               m_valid_o,
  input  wire                m_ready_i,
  output logic [NORM_W-1:0]  red_o,
  output logic [NORM_W-1:0]  green_o,
  output logic [NORM_W-1:0]  blue_o,
  output logic [COORD_W-1:0] col_o,
  output logic [COORD_W-1:0] row_o,
  output logic               last_o
);

  // round(a * 16384 / 255) for a in 0..255. Since 16384 = 64*255 + 64 the
  // result is 64a + floor((64a + 127) / 255), and the small quotient by 255
  // uses the (y + y/256 + 1) / 256 identity.
  function automatic logic [14:0] norm_mag(input logic [7:0] a);
    logic [14:0] y;
    logic [14:0] sum;
    y   = {1'b0, a, 6'b0} + 15'd127;
    sum = y + (y >> 8) + 15'd1;
    return {1'b0, a, 6'b0} + {8'b0, sum[14:8]};
  endfunction

  function automatic logic [NORM_W-1:0] norm_chan(input logic [7:0] c, input logic mode);
    logic [8:0]  twice;
    logic [8:0]  mag_in;
    logic [14:0] mag;
    twice = {c, 1'b0};
    if (!mode) begin
      return {1'b0, norm_mag(c)};
    end else if (c[7]) begin
      mag_in = twice - 9'd255;
      mag    = norm_mag(mag_in[7:0]);
      return {1'b0, mag};
    end else begin
      mag_in = 9'd255 - twice;
      mag    = norm_mag(mag_in[7:0]);
      return -{1'b0, mag};
    end
  endfunction

  logic              m_valid_q, m_valid_d;
  logic [NORM_W-1:0] red_q, green_q, blue_q;
  logic [COORD_W-1:0] col_q, row_q;
  logic              last_q;
  logic              load;

  assign item_ready_o = !m_valid_q || m_ready_i;
  assign load         = item_valid_i && item_ready_o;

  always_comb begin
    m_valid_d = m_valid_q;
    if (item_ready_o) begin
      m_valid_d = item_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      red_q   <= norm_chan({item_i.pixel[15:11], 3'b0}, norm_mode_i);
      green_q <= norm_chan({item_i.pixel[10:5], 2'b0}, norm_mode_i);
      blue_q  <= norm_chan({item_i.pixel[4:0], 3'b0}, norm_mode_i);
      col_q   <= item_i.col;
      row_q   <= item_i.row;
      last_q  <= item_i.last;
    end
  end

  assign m_valid_o = m_valid_q;
  assign red_o     = red_q;
  assign green_o   = green_q;
  assign blue_o    = blue_q;
  assign col_o     = col_q;
  assign row_o     = row_q;
  assign last_o    = last_q;

endmodule

`default_nettype wire

[rtl/core/nearest_resize_rgb565_normalize_top.sv]
// ----------------------------------------------------------------------------
// nearest_resize_rgb565_normalize_top: RGB565 downscaler and normalizer
// Usage:
//   The slave stream takes camera pixels in raster order, one request per
//   pixel; tuser marks the first pixel of a frame and clears all counters.
//   Each source pixel that lands on a nearest-neighbor grid point of the
//   target size leaves on the master stream as three signed Q2.14 channels
//   with its target column and row; tlast marks the final target pixel.
//   Other source pixels are consumed without a result.
//   Throughput is one pixel per clock while not stalled; the pick decision
//   is a few adds and compares on the row and column distance registers.
//   Stages: the pick register, then the normalization and result register.
//   The receiver may stall freely: the result register holds its request
//   and the pick stage keeps accepting until it is full as well, then the
//   slave tready drops.
//   Reset clears the counters and both pipeline stages and loads the
//   registers with 320x240 source, 96x96 target and 0..1 scaling.
//   Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i while the
//   stream is idle; a target size above the source size is clamped to it.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_resize_rgb565_normalize_top import nrr_pkg::*; #(
  parameter int MAX_DIM = 1024
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [CFG_W-1:0]       cfg_data_i,
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  // rgb565_pixel [15:0]
  input  wire [IN_TDATA_W-1:0]  s_axis_tdata,
  // frame_start
  input  wire                   s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  // red_norm [15:0], green_norm [31:16], blue_norm [47:32], out_col [57:48],
  // out_row [67:58], zero fill [71:68]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // frame_last
  output logic                  m_axis_tlast
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;

  function automatic logic [CMP_W-1:0] clamp_dim(input logic [CMP_W-1:0] v,
                                                 input logic [CMP_W-1:0] hi);
    if (v == '0) begin
      return CMP_W'(1);
    end else if (v > hi) begin
      return hi;
    end else begin
      return v;
    end
  endfunction

  logic [CFG_W-1:0] cam_w_q, cam_h_q, out_w_q, out_h_q;
  logic             norm_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_w_q     <= CAM_W_RST;
      cam_h_q     <= CAM_H_RST;
      out_w_q     <= OUT_W_RST;
      out_h_q     <= OUT_H_RST;
      norm_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CAM_W:     cam_w_q     <= cfg_data_i;
        CFG_CAM_H:     cam_h_q     <= cfg_data_i;
        CFG_OUT_W:     out_w_q     <= cfg_data_i;
        CFG_OUT_H:     out_h_q     <= cfg_data_i;
        CFG_NORM_MODE: norm_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective sizes: source limited to 1..MAX_DIM, target to 1..source.
  logic [CMP_W-1:0] cw_x, ch_x, ow_x, oh_x;
  logic [DIM_W-1:0] cw, ch, ow, oh;

  assign cw_x = clamp_dim(CMP_W'(cam_w_q), CMP_W'(MAX_DIM));
  assign ch_x = clamp_dim(CMP_W'(cam_h_q), CMP_W'(MAX_DIM));
  assign ow_x = clamp_dim(CMP_W'(out_w_q), cw_x);
  assign oh_x = clamp_dim(CMP_W'(out_h_q), ch_x);
  assign cw   = DIM_W'(cw_x);
  assign ch   = DIM_W'(ch_x);
  assign ow   = DIM_W'(ow_x);
  assign oh   = DIM_W'(oh_x);

  item_t item;
  logic  item_valid, item_ready;

  nrr_scan #(
    .MAX_DIM (MAX_DIM)
  ) u_scan (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cw_i             (cw),
    .ch_i             (ch),
    .ow_i             (ow),
    .oh_i             (oh),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .in_pixel_i       (s_axis_tdata[PIX_W-1:0]),
    .in_frame_start_i (s_axis_tuser),
    .item_valid_o     (item_valid),
    .item_o           (item),
    .item_ready_i     (item_ready)
  );

  logic [NORM_W-1:0]  red, green, blue;
  logic [COORD_W-1:0] col, row;

  nrr_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .norm_mode_i  (norm_mode_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .red_o        (red),
    .green_o      (green),
    .blue_o       (blue),
    .col_o        (col),
    .row_o        (row),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, row, col, blue, green, red};

endmodule

`default_nettype wire
